/* rtl/pbl_pkg.sv */
// ============================================================================
// Palette blend package
// Shared types and constants for the 16-entry palette lookup with blending
// and brightness scaling.
// ============================================================================
package pbl_pkg;

    // Palette geometry.
    localparam int PAL_DEPTH  = 16;
    localparam int PAL_ADDR_W = 4;
    localparam int CH_W       = 8;

    // The last entry wraps to the first when blending toward the next one.
    localparam logic [PAL_ADDR_W-1:0] PAL_LAST = 4'd15;
    localparam logic [PAL_ADDR_W-1:0] PAL_FIRST = 4'd0;

    // Brightness codes with special meaning.
    localparam logic [CH_W-1:0] BRIGHT_FULL = 8'hFF;
    localparam logic [CH_W-1:0] BRIGHT_OFF  = 8'h00;

    // Request operation codes.
    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_WRITE  = 1'b1
    } op_t;

    // One RGB color.
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    // Input request payload.
    typedef struct packed {
        op_t                   op;
        logic [11:0]           color_index;
        logic [CH_W-1:0]       brightness;
        logic [PAL_ADDR_W-1:0] entry_addr;
        logic [CH_W-1:0]       entry_red;
        logic [CH_W-1:0]       entry_green;
        logic [CH_W-1:0]       entry_blue;
    } in_item_t;

    // Result payload.
    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
    } out_item_t;

    // Palette write port controls.
    typedef struct packed {
        logic                  en;
        logic [PAL_ADDR_W-1:0] addr;
        rgb_t                  color;
    } pal_wr_t;

    // Palette dual read port controls.
    typedef struct packed {
        logic                  en;
        logic [PAL_ADDR_W-1:0] addr_a;
        logic [PAL_ADDR_W-1:0] addr_b;
    } pal_rd_t;

endpackage

/* rtl/pbl_palette_ram.sv */
// ============================================================================
// Palette memory
// Sixteen 24-bit entries with one write port and two registered read ports.
// Contents are undefined until written.
// ============================================================================
module pbl_palette_ram (
    input  logic           clk,
    input  pbl_pkg::pal_wr_t wr,
    input  pbl_pkg::pal_rd_t rd,
    output pbl_pkg::rgb_t  rd_data_a,
    output pbl_pkg::rgb_t  rd_data_b
);
    import pbl_pkg::*;

    rgb_t mem_reg [PAL_DEPTH];
    rgb_t rd_a_reg;
    rgb_t rd_b_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr.addr] <= wr.color;
        end
    end

    // Two read ports, data registered when a read is requested.
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_a_reg <= mem_reg[rd.addr_a];
            rd_b_reg <= mem_reg[rd.addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

/* rtl/palette_blend_12bit_top.sv */
// ============================================================================
// Palette blend top level
// Looks up a 16-entry RGB palette, blends toward the next entry and applies
// a brightness scale, one lookup per cycle while the output is not stalled.
// ============================================================================
// Usage:
// Requests arrive on item_valid/item_ready/item. A write request stores one
// palette entry in the accept cycle and returns no result; a lookup request
// returns one color on result_valid/result_ready/result.
// Lookups flow through four register stages: palette read, blend multiply,
// blend sum, brightness scale into the output register. A new request can
// be taken every cycle while the output is not stalled, so the sustained
// rate is one request per cycle unless the receiver stalls.
// A lookup issued the cycle after a write already sees the new entry.
// The cfg channel (cfg_valid/cfg_ready/cfg_data) sets blend_enable and is
// always ready. The user must write it only while no lookup is in flight;
// the block does not enforce this. Reset clears all stage valid bits and
// sets blend_enable to 1. The palette is not cleared and must be written
// before its entries are looked up. When the receiver stalls, the output
// register holds its result and the stages behind it keep filling bubbles;
// item_ready falls only once all four stages hold lookups.
// ============================================================================
module palette_blend_12bit_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  pbl_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output pbl_pkg::out_item_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data
);
    import pbl_pkg::*;

    // Stage payloads.
    typedef struct packed {
        logic [CH_W-1:0] frac;
        logic [CH_W-1:0] bright;
        logic            blend;
    } s1_t;

    typedef struct packed {
        rgb_t            part_a;
        rgb_t            part_b;
        logic [CH_W-1:0] bright;
    } s2_t;

    typedef struct packed {
        rgb_t            color;
        logic [CH_W-1:0] bright;
    } s3_t;

    logic      blend_enable_reg;
    logic      v1_reg, v2_reg, v3_reg, v4_reg;
    logic      en1, en2, en3, en4;
    logic      accept;
    s1_t       s1_reg, s1_next;
    s2_t       s2_reg, s2_next;
    s3_t       s3_reg, s3_next;
    out_item_t result_reg, result_next;
    pal_wr_t   pal_wr;
    pal_rd_t   pal_rd;
    rgb_t      c1, c2;
    logic [PAL_ADDR_W-1:0] hi_addr;
    logic [PAL_ADDR_W-1:0] nx_addr;
    logic [CH_W-1:0]       frac_inv;

    // Upper byte of a product of two channel values.
    function automatic logic [CH_W-1:0] scale8(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
        logic [2*CH_W-1:0] prod;
        prod = a * b;
        return prod[2*CH_W-1:CH_W];
    endfunction

    // Brightness scale of one channel.
    function automatic logic [CH_W-1:0] dim(input logic [CH_W-1:0] c,
                                            input logic [CH_W-1:0] br);
        logic [CH_W:0]     br_inc;
        logic [2*CH_W:0]   prod;
        logic [CH_W-1:0]   res;
        br_inc = {1'b0, br} + (CH_W+1)'(1);
        prod   = (2*CH_W+1)'(c) * (2*CH_W+1)'(br_inc);
        if (br == BRIGHT_FULL)
        begin
            res = c;
        end
        else if (br == BRIGHT_OFF || c == '0)
        begin
            res = '0;
        end
        else
        begin
            res = prod[2*CH_W-1:CH_W] + CH_W'(1);
        end
        return res;
    endfunction

    // Configuration register, always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_enable_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            blend_enable_reg <= cfg_data;
        end
    end

    // Per-stage advance: a stage moves when it is empty or the next one moves.
    assign en4        = !v4_reg || result_ready;
    assign en3        = !v3_reg || en4;
    assign en2        = !v2_reg || en3;
    assign en1        = !v1_reg || en2;
    assign item_ready = en1;
    assign accept     = item_valid && item_ready;

    // Palette addressing: current entry and its wrapping neighbor.
    assign hi_addr = item.color_index[11:8];
    assign nx_addr = (hi_addr == PAL_LAST) ? PAL_FIRST : hi_addr + PAL_ADDR_W'(1);

    always_comb
    begin
        pal_wr.en          = accept && (item.op == OP_WRITE);
        pal_wr.addr        = item.entry_addr;
        pal_wr.color.red   = item.entry_red;
        pal_wr.color.green = item.entry_green;
        pal_wr.color.blue  = item.entry_blue;
        pal_rd.en          = accept && (item.op == OP_LOOKUP);
        pal_rd.addr_a      = hi_addr;
        pal_rd.addr_b      = nx_addr;
    end

    pbl_palette_ram u_palette (
        .clk       (clk),
        .wr        (pal_wr),
        .rd        (pal_rd),
        .rd_data_a (c1),
        .rd_data_b (c2)
    );

    // Stage 1 side data, aligned with the registered palette read.
    always_comb
    begin
        s1_next.frac   = item.color_index[CH_W-1:0];
        s1_next.bright = item.brightness;
        s1_next.blend  = blend_enable_reg && (item.color_index[CH_W-1:0] != '0);
    end

    // Stage 2: weight both neighbors, or pass the current entry unchanged.
    assign frac_inv = BRIGHT_FULL - s1_reg.frac;

    always_comb
    begin
        s2_next.bright = s1_reg.bright;
        if (s1_reg.blend)
        begin
            s2_next.part_a.red   = scale8(c1.red,   frac_inv);
            s2_next.part_a.green = scale8(c1.green, frac_inv);
            s2_next.part_a.blue  = scale8(c1.blue,  frac_inv);
            s2_next.part_b.red   = scale8(c2.red,   s1_reg.frac);
            s2_next.part_b.green = scale8(c2.green, s1_reg.frac);
            s2_next.part_b.blue  = scale8(c2.blue,  s1_reg.frac);
        end
        else
        begin
            s2_next.part_a = c1;
            s2_next.part_b = '0;
        end
    end

    // Stage 3: sum the two weighted parts.
    always_comb
    begin
        s3_next.bright      = s2_reg.bright;
        s3_next.color.red   = s2_reg.part_a.red   + s2_reg.part_b.red;
        s3_next.color.green = s2_reg.part_a.green + s2_reg.part_b.green;
        s3_next.color.blue  = s2_reg.part_a.blue  + s2_reg.part_b.blue;
    end

    // Stage 4: brightness scaling into the output register.
    always_comb
    begin
        result_next.out_red   = dim(s3_reg.color.red,   s3_reg.bright);
        result_next.out_green = dim(s3_reg.color.green, s3_reg.bright);
        result_next.out_blue  = dim(s3_reg.color.blue,  s3_reg.bright);
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= accept && (item.op == OP_LOOKUP);
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Stage payload registers.
    always_ff @(posedge clk)
    begin
        if (pal_rd.en)
        begin
            s1_reg <= s1_next;
        end
        if (en2 && v1_reg)
        begin
            s2_reg <= s2_next;
        end
        if (en3 && v2_reg)
        begin
            s3_reg <= s3_next;
        end
        if (en4 && v3_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = v4_reg;
    assign result       = result_reg;

    // A stalled input means the first stage holds a lookup.
    a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> v1_reg)
        else $error("item_ready low with an empty first stage");

    // A palette write never enters the lookup pipeline.
    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item.op == OP_WRITE) |=> !v1_reg)
        else $error("palette write produced a lookup in the pipeline");

    // Full brightness passes the blended color through unchanged.
    a_full_bright: assert property (@(posedge clk) disable iff (!rst_n)
        (en4 && v3_reg && s3_reg.bright == BRIGHT_FULL)
        |=> (result.out_red == $past(s3_reg.color.red)
             && result.out_green == $past(s3_reg.color.green)
             && result.out_blue == $past(s3_reg.color.blue)))
        else $error("full brightness altered the color");

    // A black red channel stays black at any brightness.
    a_zero_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (en4 && v3_reg && s3_reg.color.red == '0) |=> result.out_red == '0)
        else $error("zero red channel became nonzero");

endmodule

/* sim/tb_top.sv */
// ============================================================================
// Palette blend testbench
// Drives palette writes and color lookups into palette_blend_12bit_top with
// random idle cycles on both sides. A scoreboard holds its own copy of the
// palette and blend setting, predicts each lookup color, and compares every
// result field by field. Directed lookups cover the fraction, wrap and
// brightness corners. A long receiver hold-off fills the pipeline, and random
// phases then run with blending switched on and off.
// ============================================================================
`timescale 1ns / 100ps

module tb_top;
    import pbl_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 12;
    localparam int PIPE_LATENCY = 3;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 195;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    in_item_t  req_data = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    out_item_t rsp_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data = 1'b0;

    // Scoreboard copy of the palette and the blend setting.
    logic [CH_W-1:0] pal_red   [PAL_DEPTH];
    logic [CH_W-1:0] pal_green [PAL_DEPTH];
    logic [CH_W-1:0] pal_blue  [PAL_DEPTH];
    logic            blend_on = 1'b1;
    out_item_t       color_q[$];

    // When set, neither side inserts random idle cycles.
    bit steady = 1'b0;
    int hold_request = 0;
    int hold_left = 0;
    int idle_run = 0;

    int err_count = 0;
    int n_lookups = 0;
    int n_writes = 0;
    int n_checked = 0;
    int n_cfg = 0;
    int n_in_stalls = 0;

    always #(HALF_PERIOD) clk = ~clk;

    palette_blend_12bit_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (req_valid),
        .item_ready   (req_ready),
        .item         (req_data),
        .result_valid (rsp_valid),
        .result_ready (rsp_ready),
        .result       (rsp_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Color prediction
    // ------------------------------------------------------------------------

    // Upper byte of an 8-bit by 9-bit product.
    function automatic logic [CH_W-1:0] scale8(input logic [CH_W-1:0] a,
                                               input logic [CH_W:0] b);
        logic [16:0] prod;
        prod = a * b;
        return prod[15:8];
    endfunction

    function automatic logic [CH_W-1:0] blend_chan(input logic [CH_W-1:0] c1,
                                                   input logic [CH_W-1:0] c2,
                                                   input logic [CH_W-1:0] frac);
        logic [CH_W:0] sum;
        sum = scale8(c1, 9'd255 - {1'b0, frac}) + scale8(c2, {1'b0, frac});
        return sum[CH_W-1:0];
    endfunction

    function automatic logic [CH_W-1:0] dim_chan(input logic [CH_W-1:0] c,
                                                 input logic [CH_W-1:0] br);
        if (br == BRIGHT_FULL)
            return c;
        if (br == BRIGHT_OFF || c == '0)
            return '0;
        return scale8(c, {1'b0, br} + 9'd1) + 8'd1;
    endfunction

    function automatic out_item_t predict_color(input logic [11:0] pos,
                                                input logic [CH_W-1:0] br);
        logic [PAL_ADDR_W-1:0] cur;
        logic [PAL_ADDR_W-1:0] nxt;
        logic [CH_W-1:0]       frac;
        logic [CH_W-1:0]       r;
        logic [CH_W-1:0]       g;
        logic [CH_W-1:0]       b;
        out_item_t             res;
        cur  = pos[11:8];
        frac = pos[7:0];
        nxt  = (cur == PAL_LAST) ? PAL_FIRST : cur + 4'd1;
        r = pal_red[cur];
        g = pal_green[cur];
        b = pal_blue[cur];
        if (frac != '0 && blend_on)
        begin
            r = blend_chan(r, pal_red[nxt], frac);
            g = blend_chan(g, pal_green[nxt], frac);
            b = blend_chan(b, pal_blue[nxt], frac);
        end
        res.out_red   = dim_chan(r, br);
        res.out_green = dim_chan(g, br);
        res.out_blue  = dim_chan(b, br);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard: checks results first, then records the accepted request.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (color_q.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, rsp_data);
                end
                else
                begin
                    want = color_q.pop_front();
                    n_checked++;
                    if (rsp_data.out_red !== want.out_red)
                    begin
                        err_count++;
                        $display("%0t: red mismatch, expected %h, actual %h",
                                 $time, want.out_red, rsp_data.out_red);
                    end
                    if (rsp_data.out_green !== want.out_green)
                    begin
                        err_count++;
                        $display("%0t: green mismatch, expected %h, actual %h",
                                 $time, want.out_green, rsp_data.out_green);
                    end
                    if (rsp_data.out_blue !== want.out_blue)
                    begin
                        err_count++;
                        $display("%0t: blue mismatch, expected %h, actual %h",
                                 $time, want.out_blue, rsp_data.out_blue);
                    end
                end
            end
            if (req_valid && !req_ready)
                n_in_stalls++;
            if (req_valid && req_ready)
            begin
                if (req_data.op == OP_WRITE)
                begin
                    pal_red[req_data.entry_addr]   = req_data.entry_red;
                    pal_green[req_data.entry_addr] = req_data.entry_green;
                    pal_blue[req_data.entry_addr]  = req_data.entry_blue;
                    n_writes++;
                end
                else
                begin
                    color_q.push_back(predict_color(req_data.color_index,
                                                    req_data.brightness));
                    n_lookups++;
                end
            end
            // The configuration port has a single register, the blend setting.
            if (cfg_valid && cfg_ready)
            begin
                blend_on = cfg_data;
                n_cfg++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver with random stalls and requested hold-offs.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            rsp_ready <= 1'b0;
            hold_left--;
        end
        else
            rsp_ready <= steady || ($urandom_range(99) >= 35);
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run when nothing moves for too long.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready)
            || (cfg_valid && cfg_ready))
            idle_run <= 0;
        else if (idle_run >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_run <= idle_run + 1;
    end

    // ------------------------------------------------------------------------
    // Request helpers
    // ------------------------------------------------------------------------

    // Offers one request from a falling edge and returns at the falling edge
    // after it is accepted, with valid still high.
    task automatic send_req(input in_item_t req);
        while (!steady && $urandom_range(99) < 35)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= req;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_lookup(input logic [11:0] pos, input logic [CH_W-1:0] br);
        in_item_t req;
        req = in_item_t'({$urandom, $urandom});
        req.op = OP_LOOKUP;
        req.color_index = pos;
        req.brightness = br;
        send_req(req);
    endtask

    task automatic send_write(input logic [PAL_ADDR_W-1:0] addr,
                              input logic [CH_W-1:0] r,
                              input logic [CH_W-1:0] g,
                              input logic [CH_W-1:0] b);
        in_item_t req;
        req = in_item_t'({$urandom, $urandom});
        req.op = OP_WRITE;
        req.entry_addr = addr;
        req.entry_red = r;
        req.entry_green = g;
        req.entry_blue = b;
        send_req(req);
    endtask

    // Stops offering and waits until every lookup result has come back.
    task automatic wait_idle();
        req_valid <= 1'b0;
        while (color_q.size() != 0)
            @(negedge clk);
        repeat (2 * PIPE_LATENCY) @(negedge clk);
    endtask

    task automatic set_blend(input logic en);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= en;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Channel values biased toward the extremes.
    function automatic logic [CH_W-1:0] rand_chan();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return 8'h00;
        if (pick < 20)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic logic [CH_W-1:0] rand_bright();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15)
            return BRIGHT_FULL;
        if (pick < 25)
            return BRIGHT_OFF;
        if (pick < 30)
            return 8'd1;
        if (pick < 35)
            return 8'hFE;
        return 8'($urandom);
    endfunction

    function automatic logic [11:0] rand_pos();
        logic [11:0] pos;
        pos = 12'($urandom);
        if ($urandom_range(9) == 0)
            pos[7:0] = '0;
        return pos;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Fraction, wrap, brightness corners and blend off, on a few entries.
    task automatic test_directed();
        set_blend(1'b1);
        send_write(4'd0, 8'hFF, 8'h00, 8'h80);
        send_write(4'd1, 8'h00, 8'hFF, 8'h01);
        send_write(PAL_LAST, 8'hFF, 8'hFF, 8'hFF);
        send_lookup(12'h000, BRIGHT_FULL);
        send_lookup(12'h0FF, BRIGHT_FULL);
        send_lookup(12'h080, BRIGHT_OFF);
        send_lookup(12'h040, 8'd1);
        send_lookup(12'h0C0, 8'hFE);
        // Blending from the last entry wraps to the first.
        send_lookup(12'hF80, BRIGHT_FULL);
        send_lookup(12'hFFF, 8'h80);
        // Zero channels stay zero under partial brightness.
        send_lookup(12'h100, 8'h80);
        // A lookup right behind a write must see the new entry.
        steady = 1'b1;
        send_write(4'd0, 8'h12, 8'h34, 8'h56);
        send_lookup(12'h000, BRIGHT_FULL);
        steady = 1'b0;
        set_blend(1'b0);
        send_lookup(12'h0FF, BRIGHT_FULL);
        send_lookup(12'hFFF, 8'hC8);
        set_blend(1'b1);
    endtask

    // Loads every palette entry so that any lookup afterward is legal.
    task automatic test_palette_fill();
        for (int a = 0; a < PAL_DEPTH; a++)
            send_write(PAL_ADDR_W'(a), rand_chan(), rand_chan(), rand_chan());
    endtask

    // Receiver holds off while the sender keeps offering, filling the pipe.
    task automatic test_backpressure();
        wait_idle();
        steady = 1'b1;
        hold_request = 120;
        for (int i = 0; i < 40; i++)
            send_lookup(rand_pos(), rand_bright());
        steady = 1'b0;
        // Sender pauses until every result is back.
        wait_idle();
    endtask

    // Mixed random traffic in phases with blending on and off.
    task automatic test_random_stream();
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: set_blend(1'b1);
                1: set_blend(1'b0);
                2: set_blend(1'b1);
                default: set_blend(1'($urandom));
            endcase
            steady = (p == 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(99) < 20)
                    send_write(4'($urandom), rand_chan(), rand_chan(), rand_chan());
                else
                    send_lookup(rand_pos(), rand_bright());
            end
            steady = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_palette_fill();
        test_backpressure();
        test_random_stream();
        wait_idle();
        $display("Covered %0d lookups and %0d palette writes, %0d results checked.",
                 n_lookups, n_writes, n_checked);
        $display("Blend setting written %0d times, input stalled for %0d cycles.",
                 n_cfg, n_in_stalls);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
